>>> design/ccfr_pkg.sv
// Shared constants, result codes and CRC helper for the CRC-checked frame receiver.
package ccfr_pkg;

   localparam int MAX_LENGTH_DEFAULT = 256;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_OK      = 2'd1;
   localparam logic [1:0] KIND_CRC_ERR = 2'd2;
   localparam logic [1:0] KIND_TIMEOUT = 2'd3;

   localparam logic       CSR_EXPECTED_COMMAND = 1'b0;
   localparam logic       CSR_TIMEOUT_TICKS    = 1'b1;

   localparam logic [7:0]  EXPECTED_COMMAND_RESET = 8'h3F;
   localparam logic [15:0] TIMEOUT_TICKS_RESET    = 16'd1000;

   localparam logic [7:0]  CMD_SECOND_BYTE = 8'hAA;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'hA001;
   localparam logic [15:0] IDLE_MAX        = 16'hFFFF;

   localparam int          HEADER_LEN = 6;
   localparam logic [7:0]  FRAME_HEADER [HEADER_LEN] = '{8'h7D, 8'h7B, 8'h01,
                                                         8'hF2, 8'h01, 8'h10};

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [7:0] payload_position;
      logic [8:0] frame_length;
   } rsp_fields_type;

   // CRC-16/Modbus, one byte per call, reflected
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> design/crc_checked_frame_receiver.sv
// CRC-checked frame receiver: deframes UART bytes, streams payload, reports frame status.
// A result is registered and appears on rsp in the cycle after the req acceptance that produced it.
// Throughput: one byte or tick per cycle; the byte-wide CRC update and frame state
// update finish in the accepting cycle, and the single output register holds the result.
// req_tready drops only while a result is held and rsp_tready is low.
// Reset (synchronous, active high): hunt for header, CRC 0xFFFF, registers to defaults.
module crc_checked_frame_receiver
   import ccfr_pkg::*;
#(
   parameter int MAX_LENGTH = MAX_LENGTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] payload_byte, [15:8] payload_position,
                                    // [24:16] frame_length, [31:25] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int LEN_W = $clog2(MAX_LENGTH + 1);
   localparam logic [15:0] MAX_LEN16 = 16'(MAX_LENGTH);

   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_CMD  = 3'd1;
   localparam logic [2:0] PH_LEN  = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_CRC  = 3'd4;
   localparam logic [2:0] PH_END  = 3'd5;

   logic [7:0]       exp_cmd_ff;
   logic [15:0]      timeout_ff;

   logic [2:0]       phase_ff, phase_in;
   logic [2:0]       fpos_ff, fpos_in;
   logic [LEN_W-1:0] dlen_ff, dlen_in;
   logic [LEN_W-1:0] pcnt_ff, pcnt_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       held_ff, held_in;
   logic [15:0]      idle_ff, idle_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_kind_ff, rsp_kind_in;
   rsp_fields_type   rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             emit;
   logic [1:0]       emit_kind;
   logic [7:0]       emit_byte;
   logic [7:0]       emit_pos;
   logic [15:0]      dlen16, pcnt16, len16, idle_inc;
   logic [15:0]      crc_next;
   logic [LEN_W-1:0] pcnt_next;
   logic [7:0]       b;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign crc_next   = crc_feed(crc_ff, b);
   assign dlen16     = 16'(dlen_ff);
   assign pcnt16     = 16'(pcnt_ff);
   assign len16      = {held_ff, b};
   assign pcnt_next  = pcnt_ff + 1'b1;
   assign idle_inc   = (idle_ff < IDLE_MAX) ? idle_ff + 16'd1 : idle_ff;

   always_comb begin
      phase_in  = phase_ff;
      fpos_in   = fpos_ff;
      dlen_in   = dlen_ff;
      pcnt_in   = pcnt_ff;
      crc_in    = crc_ff;
      held_in   = held_ff;
      idle_in   = idle_ff;
      emit      = 1'b0;
      emit_kind = KIND_PAYLOAD;
      emit_byte = 8'h00;
      emit_pos  = 8'h00;

      if (req_tuser) begin
         // tick
         if (phase_ff != PH_HUNT) begin
            idle_in = idle_inc;
            if (idle_inc >= timeout_ff) begin
               emit      = 1'b1;
               emit_kind = KIND_TIMEOUT;
               phase_in  = PH_HUNT;
               fpos_in   = 3'd0;
               dlen_in   = '0;
               pcnt_in   = '0;
               crc_in    = CRC_INIT;
               held_in   = 8'h00;
               idle_in   = 16'd0;
            end
         end
      end else begin
         idle_in = 16'd0;
         unique case (phase_ff)
            PH_HUNT: begin
               if (fpos_ff < 3'(HEADER_LEN) && b == FRAME_HEADER[fpos_ff]) begin
                  if (fpos_ff >= 3'd2) begin
                     crc_in = crc_next;
                  end
                  if (fpos_ff == 3'(HEADER_LEN - 1)) begin
                     phase_in = PH_CMD;
                     fpos_in  = 3'd0;
                  end else begin
                     fpos_in = fpos_ff + 3'd1;
                  end
               end else begin
                  fpos_in = 3'd0;
                  crc_in  = CRC_INIT;
               end
            end
            PH_CMD: begin
               crc_in = crc_next;
               if (fpos_ff == 3'd0) begin
                  held_in = b;
                  fpos_in = 3'd1;
               end else if (held_ff == exp_cmd_ff && b == CMD_SECOND_BYTE) begin
                  phase_in = PH_LEN;
                  fpos_in  = 3'd0;
               end else begin
                  phase_in = PH_HUNT;
                  fpos_in  = 3'd0;
                  dlen_in  = '0;
                  pcnt_in  = '0;
                  crc_in   = CRC_INIT;
                  held_in  = 8'h00;
               end
            end
            PH_LEN: begin
               crc_in = crc_next;
               if (fpos_ff == 3'd0) begin
                  held_in = b;
                  fpos_in = 3'd1;
               end else if (len16 > MAX_LEN16) begin
                  phase_in = PH_HUNT;
                  fpos_in  = 3'd0;
                  dlen_in  = '0;
                  pcnt_in  = '0;
                  crc_in   = CRC_INIT;
                  held_in  = 8'h00;
               end else begin
                  dlen_in  = LEN_W'(len16);
                  pcnt_in  = '0;
                  fpos_in  = 3'd0;
                  phase_in = (len16 == 16'd0) ? PH_CRC : PH_DATA;
               end
            end
            PH_DATA: begin
               crc_in    = crc_next;
               emit      = 1'b1;
               emit_kind = KIND_PAYLOAD;
               emit_byte = b;
               emit_pos  = pcnt16[7:0];
               pcnt_in   = pcnt_next;
               if (pcnt_next >= dlen_ff) begin
                  phase_in = PH_CRC;
                  fpos_in  = 3'd0;
               end
            end
            PH_CRC: begin
               if (fpos_ff == 3'd0) begin
                  held_in = b;
                  fpos_in = 3'd1;
               end else if ({b, held_ff} != crc_ff) begin
                  emit      = 1'b1;
                  emit_kind = KIND_CRC_ERR;
                  phase_in  = PH_HUNT;
                  fpos_in   = 3'd0;
                  dlen_in   = '0;
                  pcnt_in   = '0;
                  crc_in    = CRC_INIT;
                  held_in   = 8'h00;
               end else begin
                  phase_in = PH_END;
                  fpos_in  = 3'd0;
               end
            end
            PH_END: begin
               if (fpos_ff == 3'd0) begin
                  fpos_in = 3'd1;
               end else begin
                  emit      = 1'b1;
                  emit_kind = KIND_OK;
                  phase_in  = PH_HUNT;
                  fpos_in   = 3'd0;
                  dlen_in   = '0;
                  pcnt_in   = '0;
                  crc_in    = CRC_INIT;
                  held_in   = 8'h00;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               fpos_in  = 3'd0;
               dlen_in  = '0;
               pcnt_in  = '0;
               crc_in   = CRC_INIT;
               held_in  = 8'h00;
            end
         endcase
      end
   end

   // output register: load on an emitting transaction, hold while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept && emit) begin
         rsp_valid_in                 = 1'b1;
         rsp_kind_in                  = emit_kind;
         rsp_data_in.payload_byte     = emit_byte;
         rsp_data_in.payload_position = emit_pos;
         rsp_data_in.frame_length     = dlen16[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_cmd_ff   <= EXPECTED_COMMAND_RESET;
         timeout_ff   <= TIMEOUT_TICKS_RESET;
         phase_ff     <= PH_HUNT;
         fpos_ff      <= 3'd0;
         dlen_ff      <= '0;
         pcnt_ff      <= '0;
         crc_ff       <= CRC_INIT;
         held_ff      <= 8'h00;
         idle_ff      <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            if (csr_index == CSR_TIMEOUT_TICKS) begin
               timeout_ff <= csr_wdata;
            end else begin
               exp_cmd_ff <= csr_wdata[7:0];
            end
         end
         if (accept) begin
            phase_ff <= phase_in;
            fpos_ff  <= fpos_in;
            dlen_ff  <= dlen_in;
            pcnt_ff  <= pcnt_in;
            crc_ff   <= crc_in;
            held_ff  <= held_in;
            idle_ff  <= idle_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff.frame_length, rsp_data_ff.payload_position,
                        rsp_data_ff.payload_byte};

endmodule

>>> sim/tb_top.sv
// Testbench for the CRC-checked frame receiver: directed frames, random traffic, predicted results.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ccfr_pkg::*;

   localparam int   MAX_LEN     = MAX_LENGTH_DEFAULT;
   localparam int   QUIET_LIMIT = 1000;
   localparam int   PHASE_ITEMS = 225;
   localparam logic ACT_BYTE    = 1'b0;
   localparam logic ACT_TICK    = 1'b1;

   typedef enum logic [2:0] {PH_HUNT, PH_CMD, PH_LEN, PH_DATA, PH_CRC, PH_END} frame_phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] pbyte;
      logic [7:0] ppos;
      logic [8:0] flen;
   } rsp_item_type;

   // where a directed byte comes from: literal, or derived from the running CRC
   typedef enum logic [1:0] {SRC_LIT, SRC_CRC_LO, SRC_CRC_HI, SRC_CRC_BAD} row_src_type;

   typedef struct packed {
      logic         act;
      row_src_type  src;
      logic [7:0]   data;
      bit           typed;
      rsp_item_type res;
   } dir_row_type;

   localparam rsp_item_type NO_RES   = '0;
   localparam int           DIR_ROWS = 32;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] rx_byte
   logic        req_tuser  = 1'b0;    // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [7:0] byte, [15:8] position, [24:16] length
   logic [1:0]  rsp_tuser;            // [1:0] kind
   logic        csr_wen    = 1'b0;
   logic        csr_index  = 1'b0;
   logic [15:0] csr_wdata  = 16'h0000;

   // predictor state and register copies
   frame_phase_type fr_phase;
   logic [2:0]   fr_pos;
   logic [8:0]   fr_len;
   logic [8:0]   fr_count;
   logic [15:0]  fr_crc;
   logic [7:0]   fr_held;
   logic [15:0]  fr_idle;
   logic [7:0]   cfg_command;
   logic [15:0]  cfg_timeout;

   rsp_item_type expected_reports[$];
   int        mismatches    = 0;
   int        items_sent    = 0;
   int        req_gap_max   = 5;
   int        rsp_stall_max = 5;
   int        stall_left    = 0;
   int        quiet_cycles  = 0;
   int        frame_byte_idx;
   int        burst_at;

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{ACT_TICK, SRC_LIT, 8'hFF, 1'b0, NO_RES},    // tick while hunting
      '{ACT_BYTE, SRC_LIT, 8'h7D, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'h7D, 1'b0, NO_RES},    // breaks the header, not rechecked
      '{ACT_BYTE, SRC_LIT, 8'h7B, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'h7D, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'h7B, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'h01, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'hF2, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'h01, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'h10, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'h3F, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'hAA, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'h00, 1'b0, NO_RES},
      '{ACT_TICK, SRC_LIT, 8'h00, 1'b0, NO_RES},    // idle tick inside a frame
      '{ACT_BYTE, SRC_LIT, 8'h01, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'hFF, 1'b1, '{KIND_PAYLOAD, 8'hFF, 8'h00, 9'd1}},
      '{ACT_BYTE, SRC_CRC_LO, 8'h00, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_CRC_HI, 8'h00, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'h00, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'hFF, 1'b1, '{KIND_OK, 8'h00, 8'h00, 9'd1}},
      '{ACT_BYTE, SRC_LIT, 8'h7D, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'h7B, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'h01, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'hF2, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'h01, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'h10, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'h3F, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'hAA, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'h00, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_LIT, 8'h00, 1'b0, NO_RES},    // zero length, straight to CRC
      '{ACT_BYTE, SRC_CRC_BAD, 8'h00, 1'b0, NO_RES},
      '{ACT_BYTE, SRC_CRC_HI, 8'h00, 1'b1, '{KIND_CRC_ERR, 8'h00, 8'h00, 9'd0}}
   };

   crc_checked_frame_receiver uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [15:0] modbus_crc_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      acc = crc ^ {8'h00, b};
      repeat (8) acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      return acc;
   endfunction

   function automatic rsp_item_type frame_report(input logic [1:0] k, input logic [7:0] pb,
                                                 input logic [7:0] pp);
      rsp_item_type r;
      r.kind  = k;
      r.pbyte = pb;
      r.ppos  = pp;
      r.flen  = fr_len;
      return r;
   endfunction

   task automatic clear_frame();
      fr_phase = PH_HUNT;
      fr_pos   = '0;
      fr_len   = '0;
      fr_count = '0;
      fr_crc   = CRC_INIT;
      fr_held  = '0;
      fr_idle  = '0;
   endtask

   // advances the deframer state by one byte or tick
   task automatic deframe_step(input logic act, input logic [7:0] b,
                               output bit got, output rsp_item_type res);
      logic [15:0] word;
      got = 1'b0;
      res = '0;
      if (act == ACT_TICK) begin
         if (fr_phase != PH_HUNT) begin
            if (fr_idle != IDLE_MAX) fr_idle++;
            if (fr_idle >= cfg_timeout) begin
               res = frame_report(KIND_TIMEOUT, 8'h00, 8'h00);
               got = 1'b1;
               clear_frame();
            end
         end
         return;
      end
      fr_idle = '0;
      case (fr_phase)
         PH_HUNT: begin
            if (b == FRAME_HEADER[fr_pos]) begin
               if (fr_pos >= 2) fr_crc = modbus_crc_next(fr_crc, b);
               if (fr_pos == HEADER_LEN - 1) begin
                  fr_phase = PH_CMD;
                  fr_pos   = '0;
               end else begin
                  fr_pos++;
               end
            end else begin
               fr_pos = '0;
               fr_crc = CRC_INIT;
            end
         end
         PH_CMD: begin
            fr_crc = modbus_crc_next(fr_crc, b);
            if (fr_pos == 0) begin
               fr_held = b;
               fr_pos  = 3'd1;
            end else if (fr_held == cfg_command && b == CMD_SECOND_BYTE) begin
               fr_phase = PH_LEN;
               fr_pos   = '0;
            end else begin
               clear_frame();
            end
         end
         PH_LEN: begin
            fr_crc = modbus_crc_next(fr_crc, b);
            if (fr_pos == 0) begin
               fr_held = b;
               fr_pos  = 3'd1;
            end else begin
               word = {fr_held, b};
               if (word > MAX_LEN) begin
                  clear_frame();
               end else begin
                  fr_len   = word[8:0];
                  fr_count = '0;
                  fr_pos   = '0;
                  if (word == 0) fr_phase = PH_CRC;
                  else fr_phase = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            fr_crc = modbus_crc_next(fr_crc, b);
            res = frame_report(KIND_PAYLOAD, b, fr_count[7:0]);
            got = 1'b1;
            fr_count++;
            if (fr_count >= fr_len) begin
               fr_phase = PH_CRC;
               fr_pos   = '0;
            end
         end
         PH_CRC: begin
            if (fr_pos == 0) begin
               fr_held = b;
               fr_pos  = 3'd1;
            end else begin
               // CRC arrives low byte first
               word = {b, fr_held};
               if (word != fr_crc) begin
                  res = frame_report(KIND_CRC_ERR, 8'h00, 8'h00);
                  got = 1'b1;
                  clear_frame();
               end else begin
                  fr_phase = PH_END;
                  fr_pos   = '0;
               end
            end
         end
         PH_END: begin
            if (fr_pos == 0) begin
               fr_pos = 3'd1;
            end else begin
               res = frame_report(KIND_OK, 8'h00, 8'h00);
               got = 1'b1;
               clear_frame();
            end
         end
         default: clear_frame();
      endcase
   endtask

   task automatic push_req(input logic act, input logic [7:0] b, input bit typed = 1'b0,
                           input rsp_item_type typed_res = '0);
      int           gap;
      bit           got;
      rsp_item_type res;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      deframe_step(act, b, got, res);
      if (typed) expected_reports.push_back(typed_res);
      else if (got) expected_reports.push_back(res);
      items_sent++;
   endtask

   // byte inside a frame, with stray ticks and the occasional timeout burst ahead of it
   task automatic feed_byte(input logic [7:0] b);
      int tick_pct;
      tick_pct = (cfg_timeout < 3) ? 3 : 12;
      if ($urandom_range(0, 99) < tick_pct)
         repeat ($urandom_range(1, 2)) push_req(ACT_TICK, 8'($urandom));
      if (frame_byte_idx == burst_at)
         repeat (cfg_timeout) push_req(ACT_TICK, 8'($urandom));
      frame_byte_idx++;
      push_req(ACT_BYTE, b);
   endtask

   task automatic send_frame(input int force_len);
      int          bad_at;
      int          len;
      int          pick;
      logic [15:0] len_word;
      logic [15:0] crc_word;
      frame_byte_idx = 0;
      burst_at = (cfg_timeout <= 40 && $urandom_range(0, 9) == 0) ? $urandom_range(0, 14) : -1;
      bad_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, HEADER_LEN - 1) : -1;
      pick     = $urandom_range(0, 99);
      if (force_len >= 0) len = force_len;
      else if (pick < 84) len = $urandom_range(0, 6);
      else if (pick < 94) len = $urandom_range(7, 40);
      else if (pick < 96) len = $urandom_range(41, MAX_LEN - 1);
      else if (pick < 97) len = MAX_LEN;
      else if (pick < 98) len = MAX_LEN + 1;
      else len = $urandom_range(MAX_LEN + 2, 65535);
      for (int i = 0; i < HEADER_LEN; i++)
         feed_byte((i == bad_at) ? (FRAME_HEADER[i] ^ 8'($urandom_range(1, 255)))
                                 : FRAME_HEADER[i]);
      feed_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : cfg_command);
      feed_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : CMD_SECOND_BYTE);
      len_word = 16'(len);
      feed_byte(len_word[15:8]);
      feed_byte(len_word[7:0]);
      if (len > MAX_LEN) return;
      repeat (len) feed_byte(8'($urandom));
      crc_word = fr_crc;
      if ($urandom_range(0, 5) == 0) crc_word ^= 16'(1 << $urandom_range(0, 15));
      feed_byte(crc_word[7:0]);
      feed_byte(crc_word[15:8]);
      feed_byte(8'($urandom));
      feed_byte(8'($urandom));
   endtask

   // drain all expected results, then let the pipeline go idle
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_config(input logic [7:0] cmd, input logic [15:0] ticks);
      csr_wen   <= 1'b1;
      csr_index <= CSR_EXPECTED_COMMAND;
      csr_wdata <= {8'h00, cmd};
      @(posedge clock);
      csr_index <= CSR_TIMEOUT_TICKS;
      csr_wdata <= ticks;
      @(posedge clock);
      csr_wen <= 1'b0;
      cfg_command = cmd;
      cfg_timeout = ticks;
   endtask

   // stimulus
   initial begin
      logic [7:0]  cmd_set  [4];
      logic [15:0] tick_set [4];
      logic [7:0]  b;
      int          phase_start;
      cfg_command = EXPECTED_COMMAND_RESET;
      cfg_timeout = TIMEOUT_TICKS_RESET;
      clear_frame();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         case (dir_rows[i].src)
            SRC_CRC_LO:  b = fr_crc[7:0];
            SRC_CRC_HI:  b = fr_crc[15:8];
            SRC_CRC_BAD: b = ~fr_crc[7:0];
            default:     b = dir_rows[i].data;
         endcase
         push_req(dir_rows[i].act, b, dir_rows[i].typed, dir_rows[i].res);
      end

      cmd_set  = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
      tick_set = '{16'd1, 16'hFFFF, 16'($urandom_range(2, 30)), 16'd1000};
      for (int p = 0; p < 4; p++) begin
         settle();
         write_config(cmd_set[p], tick_set[p]);
         phase_start = items_sent;
         if (p == 1) send_frame(MAX_LEN);
         while (items_sent - phase_start < PHASE_ITEMS) begin
            req_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 5;
            rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 6))
                  push_req(($urandom_range(0, 3) == 0) ? ACT_TICK : ACT_BYTE, 8'($urandom));
            else
               send_frame(-1);
         end
      end

      settle();
      if (mismatches == 0 && expected_reports.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // result side: backpressure and checking
   always @(posedge clock) begin : rsp_side
      rsp_item_type want;
      logic [31:0]  want_data;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected transaction: kind=%0d data=%h", rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want      = expected_reports.pop_front();
               want_data = {7'd0, want.flen, want.ppos, want.pbyte};
               if (rsp_tuser !== want.kind || rsp_tdata !== want_data) begin
                  if (mismatches < 10) begin
                     $display("mismatch: kind exp %0d got %0d, byte exp %h got %h",
                              want.kind, rsp_tuser, want.pbyte, rsp_tdata[7:0]);
                     $display("   pos exp %0d got %0d, len exp %0d got %0d, pad %h",
                              want.ppos, rsp_tdata[15:8], want.flen, rsp_tdata[24:16],
                              rsp_tdata[31:25]);
                  end
                  mismatches++;
               end
            end
            stall_left = $urandom_range(0, rsp_stall_max);
            rsp_tready <= (stall_left == 0);
         end else if (!rsp_tready) begin
            if (stall_left <= 1) begin
               stall_left = 0;
               rsp_tready <= 1'b1;
            end else begin
               stall_left--;
            end
         end
      end
   end

   // watchdog: ends the run if no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

>>> filelist.f
design/ccfr_pkg.sv
design/crc_checked_frame_receiver.sv
sim/tb_top.sv
